/* rtl/slvd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Status slot line validator package
// Types, codes and constants shared by the validator modules.
// ----------------------------------------------------------------------------
package slvd_pkg;

    localparam int SLOT_COUNT     = 3;
    localparam int MAX_LINE_BYTES = 1024;

    localparam int COUNT_W   = 11;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = 2;
    localparam int RES_CNT_W = 3;

    localparam logic [COUNT_W-1:0] COUNT_SAT = 11'h7FF;
    localparam logic [COUNT_W-1:0] LINE_LIMIT = COUNT_W'(MAX_LINE_BYTES);
    localparam logic [3:0]         SLOT_LIMIT = 4'(SLOT_COUNT);

    localparam logic [CFG_IDX_W-1:0] REG_TEXT_KIND   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LARGEST_KIND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LARGEST_ICON = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIDDLE_CAP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_CAP    = 3'd4;

    localparam logic [7:0] RST_TEXT_KIND    = 8'd1;
    localparam logic [7:0] RST_LARGEST_KIND = 8'd3;
    localparam logic [7:0] RST_LARGEST_ICON = 8'd63;
    localparam logic [7:0] RST_MIDDLE_CAP   = 8'd32;
    localparam logic [7:0] RST_EDGE_CAP     = 8'd16;

    localparam logic [7:0] UTF_CONT_MASK = 8'hC0;
    localparam logic [7:0] UTF_CONT_TAG  = 8'h80;
    localparam logic [7:0] UTF_LEAD_MASK = 8'hF0;
    localparam logic [7:0] UTF_ASCII_TOP = 8'h80;
    localparam logic [7:0] UTF_TWO_LO    = 8'hC2;
    localparam logic [7:0] UTF_TWO_HI    = 8'hDF;
    localparam logic [7:0] UTF_THREE_E0  = 8'hE0;
    localparam logic [7:0] UTF_THREE_ED  = 8'hED;
    localparam logic [7:0] UTF_FOUR_F0   = 8'hF0;
    localparam logic [7:0] UTF_FOUR_F4   = 8'hF4;
    localparam logic [7:0] UTF_BOUND_A0  = 8'hA0;
    localparam logic [7:0] UTF_BOUND_9F  = 8'h9F;
    localparam logic [7:0] UTF_BOUND_90  = 8'h90;
    localparam logic [7:0] UTF_BOUND_8F  = 8'h8F;

    typedef enum logic [2:0] {
        PH_KIND,
        PH_ICON,
        PH_LEN,
        PH_TEXT,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        RULE_NONE,
        RULE_GE_A0,
        RULE_LE_9F,
        RULE_GE_90,
        RULE_LE_8F
    } rule_t;

    typedef struct packed {
        logic [7:0] text_kind_code;
        logic [7:0] largest_kind;
        logic [7:0] largest_icon;
        logic [7:0] middle_text_cap;
        logic [7:0] edge_text_cap;
    } cfg_t;

    typedef struct packed {
        phase_t             phase;
        logic [2:0]         slot_counter;
        logic [COUNT_W-1:0] byte_count;
        logic [7:0]         held_kind;
        logic [7:0]         held_icon;
        logic [7:0]         held_length;
        logic [7:0]         text_remaining;
        logic [1:0]         cont_pending;
        rule_t              rule;
        logic               error_seen;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:          PH_KIND,
        slot_counter:   3'd0,
        byte_count:     '0,
        held_kind:      8'd0,
        held_icon:      8'd0,
        held_length:    8'd0,
        text_remaining: 8'd0,
        cont_pending:   2'd0,
        rule:           RULE_NONE,
        error_seen:     1'b0
    };

    typedef struct packed {
        logic       is_verdict;
        logic [2:0] slot_number;
        logic [7:0] slot_kind;
        logic [7:0] slot_icon;
        logic [7:0] text_length;
        logic [9:0] text_offset;
        logic       line_ok;
        logic       last;
    } result_t;

endpackage : slvd_pkg
`default_nettype wire

/* rtl/slvd_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Status slot line validator channels
// Byte input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface slvd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_line;

    modport source (output valid, output data_byte, output end_of_line, input ready);
    modport sink   (input valid, input data_byte, input end_of_line, output ready);
endinterface : slvd_in_if

interface slvd_out_if;
    logic       valid;
    logic       ready;
    logic       is_verdict;
    logic [2:0] slot_number;
    logic [7:0] slot_kind;
    logic [7:0] slot_icon;
    logic [7:0] text_length;
    logic [9:0] text_offset;
    logic       line_ok;
    logic       last;

    modport source (
        output valid, output is_verdict, output slot_number, output slot_kind,
        output slot_icon, output text_length, output text_offset, output line_ok,
        output last, input ready
    );
    modport sink (
        input valid, input is_verdict, input slot_number, input slot_kind,
        input slot_icon, input text_length, input text_offset, input line_ok,
        input last, output ready
    );
endinterface : slvd_out_if
`default_nettype wire

/* rtl/slvd_parse.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Status slot line validator byte parser
// Next line state and up to two results for one accepted byte.
// ----------------------------------------------------------------------------
module slvd_parse (
    input  slvd_pkg::cfg_t    cfg,
    input  slvd_pkg::state_t  cur,
    input  logic [7:0]        data_byte,
    input  logic              end_of_line,
    output slvd_pkg::state_t  nxt,
    output slvd_pkg::result_t res0,
    output slvd_pkg::result_t res1,
    output logic [1:0]        res_count
);
    import slvd_pkg::*;

    logic       err;
    logic       desc_valid;
    logic [7:0] desc_length;
    logic [9:0] desc_offset;
    logic [7:0] cap;
    logic       utf_ok;
    logic [2:0] slot_inc;
    logic [7:0] remain_dec;
    logic [COUNT_W-1:0] text_start;
    result_t    desc;
    result_t    verdict;

    assign slot_inc   = cur.slot_counter + 3'd1;
    assign remain_dec = cur.text_remaining - 8'd1;
    assign cap        = (cur.slot_counter == 3'd1) ? cfg.middle_text_cap : cfg.edge_text_cap;
    assign text_start = cur.byte_count + COUNT_W'(1) - COUNT_W'(cur.held_length);

    always_comb
    begin
        nxt         = cur;
        err         = cur.error_seen;
        desc_valid  = 1'b0;
        desc_length = 8'd0;
        desc_offset = 10'd0;
        utf_ok      = 1'b1;

        if (cur.byte_count != COUNT_SAT)
        begin
            nxt.byte_count = cur.byte_count + COUNT_W'(1);
        end
        if (!err && (nxt.byte_count > LINE_LIMIT))
        begin
            err = 1'b1;
        end

        if (!err)
        begin
            case (cur.phase)
                PH_KIND:
                begin
                    nxt.held_kind = data_byte;
                    nxt.phase     = PH_ICON;
                end
                PH_ICON:
                begin
                    nxt.held_icon = data_byte;
                    nxt.phase     = PH_LEN;
                end
                PH_LEN:
                begin
                    nxt.held_length = data_byte;
                    if ((cur.held_kind > cfg.largest_kind) || (cur.held_icon > cfg.largest_icon))
                    begin
                        err = 1'b1;
                    end
                    else if (cur.held_kind == cfg.text_kind_code)
                    begin
                        if ((data_byte == 8'd0) || (data_byte > cap))
                        begin
                            err = 1'b1;
                        end
                        else
                        begin
                            nxt.text_remaining = data_byte;
                            nxt.cont_pending   = 2'd0;
                            nxt.rule           = RULE_NONE;
                            nxt.phase          = PH_TEXT;
                        end
                    end
                    else if (data_byte != 8'd0)
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        desc_valid = 1'b1;
                    end
                end
                PH_TEXT:
                begin
                    if (cur.cont_pending != 2'd0)
                    begin
                        if ((data_byte & UTF_CONT_MASK) != UTF_CONT_TAG)
                        begin
                            utf_ok = 1'b0;
                        end
                        else
                        begin
                            case (cur.rule)
                                RULE_GE_A0: utf_ok = (data_byte >= UTF_BOUND_A0);
                                RULE_LE_9F: utf_ok = (data_byte <= UTF_BOUND_9F);
                                RULE_GE_90: utf_ok = (data_byte >= UTF_BOUND_90);
                                RULE_LE_8F: utf_ok = (data_byte <= UTF_BOUND_8F);
                                default:    utf_ok = 1'b1;
                            endcase
                        end
                        nxt.rule         = RULE_NONE;
                        nxt.cont_pending = cur.cont_pending - 2'd1;
                    end
                    else
                    begin
                        nxt.rule = RULE_NONE;
                        if (data_byte < UTF_ASCII_TOP)
                        begin
                            nxt.cont_pending = 2'd0;
                        end
                        else if ((data_byte >= UTF_TWO_LO) && (data_byte <= UTF_TWO_HI))
                        begin
                            nxt.cont_pending = 2'd1;
                        end
                        else if ((data_byte & UTF_LEAD_MASK) == UTF_THREE_E0)
                        begin
                            nxt.cont_pending = 2'd2;
                            if (data_byte == UTF_THREE_E0)
                            begin
                                nxt.rule = RULE_GE_A0;
                            end
                            else if (data_byte == UTF_THREE_ED)
                            begin
                                nxt.rule = RULE_LE_9F;
                            end
                        end
                        else if ((data_byte >= UTF_FOUR_F0) && (data_byte <= UTF_FOUR_F4))
                        begin
                            nxt.cont_pending = 2'd3;
                            if (data_byte == UTF_FOUR_F0)
                            begin
                                nxt.rule = RULE_GE_90;
                            end
                            else if (data_byte == UTF_FOUR_F4)
                            begin
                                nxt.rule = RULE_LE_8F;
                            end
                        end
                        else
                        begin
                            utf_ok = 1'b0;
                        end
                    end

                    if (!utf_ok)
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        nxt.text_remaining = remain_dec;
                        if (remain_dec == 8'd0)
                        begin
                            if (nxt.cont_pending != 2'd0)
                            begin
                                err = 1'b1;
                            end
                            else
                            begin
                                desc_valid  = 1'b1;
                                desc_length = cur.held_length;
                                desc_offset = text_start[9:0];
                            end
                        end
                    end
                end
                default:
                begin
                    err = 1'b1;
                end
            endcase
        end

        if (desc_valid)
        begin
            nxt.slot_counter = slot_inc;
            if ((slot_inc == 3'd0) || ({1'b0, slot_inc} >= SLOT_LIMIT))
            begin
                nxt.phase = PH_DONE;
            end
            else
            begin
                nxt.phase = PH_KIND;
            end
        end

        nxt.error_seen = err;

        desc.is_verdict  = 1'b0;
        desc.slot_number = cur.slot_counter;
        desc.slot_kind   = cur.held_kind;
        desc.slot_icon   = (cur.phase == PH_LEN) ? cur.held_icon : cur.held_icon;
        desc.text_length = desc_length;
        desc.text_offset = desc_offset;
        desc.line_ok     = 1'b0;
        desc.last        = !end_of_line;

        verdict.is_verdict  = 1'b1;
        verdict.slot_number = 3'd0;
        verdict.slot_kind   = 8'd0;
        verdict.slot_icon   = 8'd0;
        verdict.text_length = 8'd0;
        verdict.text_offset = 10'd0;
        verdict.line_ok     = !err && (nxt.phase == PH_DONE);
        verdict.last        = 1'b1;

        if (end_of_line)
        begin
            nxt = STATE_RESET;
        end

        if (desc_valid)
        begin
            res0      = desc;
            res1      = verdict;
            res_count = end_of_line ? 2'd2 : 2'd1;
        end
        else
        begin
            res0      = verdict;
            res1      = verdict;
            res_count = end_of_line ? 2'd1 : 2'd0;
        end
    end

endmodule : slvd_parse
`default_nettype wire

/* rtl/slvd_rqueue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Status slot line validator result queue
// Four-entry queue that takes up to two results a cycle and gives one.
// ----------------------------------------------------------------------------
module slvd_rqueue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        push_count,
    input  slvd_pkg::result_t push0,
    input  slvd_pkg::result_t push1,
    output logic              room,
    output logic              head_valid,
    output slvd_pkg::result_t head,
    input  logic              pop
);
    import slvd_pkg::*;

    result_t               mem [RES_DEPTH];
    logic [RES_PTR_W-1:0]  wr_ptr_reg;
    logic [RES_PTR_W-1:0]  wr_ptr_next;
    logic [RES_PTR_W-1:0]  rd_ptr_reg;
    logic [RES_PTR_W-1:0]  rd_ptr_next;
    logic [RES_CNT_W-1:0]  count_reg;
    logic [RES_CNT_W-1:0]  count_next;
    logic                  do_pop;

    assign do_pop     = pop && (count_reg != '0);
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign room       = (count_reg <= RES_CNT_W'(RES_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + RES_PTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + RES_PTR_W'(do_pop);
        count_next  = count_reg + RES_CNT_W'(push_count) - RES_CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2)
        begin
            mem[wr_ptr_reg + RES_PTR_W'(1)] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule : slvd_rqueue
`default_nettype wire

/* rtl/status_slot_line_validator_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Status slot line validator
// Checks a byte-wise status line of slots and reports slots and a verdict.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle while the result queue has room. Each
// byte is parsed against the line state in the same cycle it transfers;
// the results it causes, if any (a slot descriptor, the line verdict on the
// end-of-line byte, or both), go into a four-entry result queue that
// delivers one result per cycle while the sink is ready. The input stalls
// only while the queue holds more than two results, so a sink that is always
// ready sees one byte per cycle sustained; results are registered in the queue.
// ----------------------------------------------------------------------------
module status_slot_line_validator_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [slvd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [slvd_pkg::CFG_DATA_W-1:0]    cfg_data,
    slvd_in_if.sink                            in_ch,
    slvd_out_if.source                         out_ch
);
    import slvd_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    state_t     state_reg;
    state_t     state_parsed;
    state_t     state_next;
    result_t    res0;
    result_t    res1;
    result_t    head;
    logic [1:0] res_count;
    logic [1:0] push_count;
    logic       room;
    logic       head_valid;
    logic       in_xfer;

    assign in_ch.ready = room;
    assign in_xfer     = in_ch.valid && room;
    assign push_count  = in_xfer ? res_count : 2'd0;
    assign state_next  = in_xfer ? state_parsed : state_reg;

    slvd_parse u_parse (
        .cfg         (cfg_reg),
        .cur         (state_reg),
        .data_byte   (in_ch.data_byte),
        .end_of_line (in_ch.end_of_line),
        .nxt         (state_parsed),
        .res0        (res0),
        .res1        (res1),
        .res_count   (res_count)
    );

    slvd_rqueue u_rqueue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push0      (res0),
        .push1      (res1),
        .room       (room),
        .head_valid (head_valid),
        .head       (head),
        .pop        (out_ch.ready)
    );

    assign out_ch.valid       = head_valid;
    assign out_ch.is_verdict  = head.is_verdict;
    assign out_ch.slot_number = head.slot_number;
    assign out_ch.slot_kind   = head.slot_kind;
    assign out_ch.slot_icon   = head.slot_icon;
    assign out_ch.text_length = head.text_length;
    assign out_ch.text_offset = head.text_offset;
    assign out_ch.line_ok     = head.line_ok;
    assign out_ch.last        = head.last;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_TEXT_KIND:    cfg_next.text_kind_code  = cfg_data;
                REG_LARGEST_KIND: cfg_next.largest_kind    = cfg_data;
                REG_LARGEST_ICON: cfg_next.largest_icon    = cfg_data;
                REG_MIDDLE_CAP:   cfg_next.middle_text_cap = cfg_data;
                REG_EDGE_CAP:     cfg_next.edge_text_cap   = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.text_kind_code  <= RST_TEXT_KIND;
            cfg_reg.largest_kind    <= RST_LARGEST_KIND;
            cfg_reg.largest_icon    <= RST_LARGEST_ICON;
            cfg_reg.middle_text_cap <= RST_MIDDLE_CAP;
            cfg_reg.edge_text_cap   <= RST_EDGE_CAP;
            state_reg               <= STATE_RESET;
        end
        else
        begin
            cfg_reg   <= cfg_next;
            state_reg <= state_next;
        end
    end

endmodule : status_slot_line_validator_core
`default_nettype wire

/* tb/status_line_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Status line checker
// Follows every byte transfer and register write of the validator, rebuilds
// the slot and UTF-8 state of the current line, and compares each result
// transfer field by field with the oldest predicted slot report or verdict.
// ----------------------------------------------------------------------------
module status_line_checker
    import slvd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    slvd_in_if                    byte_ch,
    slvd_out_if                   report_ch,
    output int unsigned           mismatches,
    output int unsigned           reports_due
);

    cfg_t               limits;
    phase_t             ph;
    logic [2:0]         slot_idx;
    logic [COUNT_W-1:0] line_count;
    logic [7:0]         kind_hold;
    logic [7:0]         icon_hold;
    logic [7:0]         len_hold;
    logic [7:0]         text_left;
    logic [1:0]         cont_left;
    rule_t              lead_rule;
    logic               line_bad;
    result_t            awaited_reports[$];

    task automatic clear_line_state();
        ph         = PH_KIND;
        slot_idx   = 3'd0;
        line_count = '0;
        kind_hold  = 8'd0;
        icon_hold  = 8'd0;
        len_hold   = 8'd0;
        text_left  = 8'd0;
        cont_left  = 2'd0;
        lead_rule  = RULE_NONE;
        line_bad   = 1'b0;
    endtask

    task automatic queue_report(input logic verdict, input logic [2:0] slot,
                                input logic [7:0] kind, input logic [7:0] icon,
                                input logic [7:0] tlen, input logic [9:0] toff,
                                input logic ok);
        result_t r;
        r.is_verdict  = verdict;
        r.slot_number = slot;
        r.slot_kind   = kind;
        r.slot_icon   = icon;
        r.text_length = tlen;
        r.text_offset = toff;
        r.line_ok     = ok;
        r.last        = 1'b0;
        awaited_reports.push_back(r);
    endtask

    task automatic close_slot(input logic [7:0] tlen, input logic [9:0] toff);
        queue_report(1'b0, slot_idx, kind_hold, icon_hold, tlen, toff, 1'b0);
        slot_idx = slot_idx + 3'd1;
        if (slot_idx == 3'd0 || slot_idx >= SLOT_COUNT)
            ph = PH_DONE;
        else
            ph = PH_KIND;
    endtask

    function automatic logic utf8_step(input logic [7:0] b);
        if (cont_left != 2'd0)
        begin
            if ((b & UTF_CONT_MASK) != UTF_CONT_TAG)
                return 1'b0;
            case (lead_rule)
                RULE_GE_A0: if (b < UTF_BOUND_A0) return 1'b0;
                RULE_LE_9F: if (b > UTF_BOUND_9F) return 1'b0;
                RULE_GE_90: if (b < UTF_BOUND_90) return 1'b0;
                RULE_LE_8F: if (b > UTF_BOUND_8F) return 1'b0;
                default: ;
            endcase
            lead_rule = RULE_NONE;
            cont_left = cont_left - 2'd1;
            return 1'b1;
        end
        lead_rule = RULE_NONE;
        if (b < UTF_ASCII_TOP)
            cont_left = 2'd0;
        else if (b >= UTF_TWO_LO && b <= UTF_TWO_HI)
            cont_left = 2'd1;
        else if ((b & UTF_LEAD_MASK) == UTF_THREE_E0)
        begin
            cont_left = 2'd2;
            if (b == UTF_THREE_E0)
                lead_rule = RULE_GE_A0;
            else if (b == UTF_THREE_ED)
                lead_rule = RULE_LE_9F;
        end
        else if (b >= UTF_FOUR_F0 && b <= UTF_FOUR_F4)
        begin
            cont_left = 2'd3;
            if (b == UTF_FOUR_F0)
                lead_rule = RULE_GE_90;
            else if (b == UTF_FOUR_F4)
                lead_rule = RULE_LE_8F;
        end
        else
            return 1'b0;
        return 1'b1;
    endfunction

    task automatic parse_line_byte(input logic [7:0] b, input logic eol);
        logic [COUNT_W-1:0] off;
        logic [7:0]         cap;
        int                 queued;
        result_t            tail;
        queued = awaited_reports.size();
        off = line_count;
        if (line_count != COUNT_SAT)
            line_count = line_count + 1'b1;
        if (!line_bad && line_count > LINE_LIMIT)
            line_bad = 1'b1;
        if (!line_bad)
        begin
            case (ph)
                PH_KIND:
                begin
                    kind_hold = b;
                    ph = PH_ICON;
                end
                PH_ICON:
                begin
                    icon_hold = b;
                    ph = PH_LEN;
                end
                PH_LEN:
                begin
                    len_hold = b;
                    cap = (slot_idx == 3'd1) ? limits.middle_text_cap : limits.edge_text_cap;
                    if (kind_hold > limits.largest_kind || icon_hold > limits.largest_icon)
                        line_bad = 1'b1;
                    else if (kind_hold == limits.text_kind_code)
                    begin
                        if (b == 8'd0 || b > cap)
                            line_bad = 1'b1;
                        else
                        begin
                            text_left = b;
                            cont_left = 2'd0;
                            lead_rule = RULE_NONE;
                            ph = PH_TEXT;
                        end
                    end
                    else if (b != 8'd0)
                        line_bad = 1'b1;
                    else
                        close_slot(8'd0, 10'd0);
                end
                PH_TEXT:
                begin
                    if (!utf8_step(b))
                        line_bad = 1'b1;
                    else
                    begin
                        text_left = text_left - 8'd1;
                        if (text_left == 8'd0)
                        begin
                            if (cont_left != 2'd0)
                                line_bad = 1'b1;
                            else
                                close_slot(len_hold, 10'(off + 1'b1 - len_hold));
                        end
                    end
                end
                default: line_bad = 1'b1;
            endcase
        end
        if (eol)
        begin
            queue_report(1'b1, 3'd0, 8'd0, 8'd0, 8'd0, 10'd0, !line_bad && ph == PH_DONE);
            clear_line_state();
        end
        if (awaited_reports.size() > queued)
        begin
            tail = awaited_reports.pop_back();
            tail.last = 1'b1;
            awaited_reports.push_back(tail);
        end
    endtask

    task automatic check_field(input string name, input logic [9:0] want,
                               input logic [9:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            limits = '{text_kind_code:  RST_TEXT_KIND,
                       largest_kind:    RST_LARGEST_KIND,
                       largest_icon:    RST_LARGEST_ICON,
                       middle_text_cap: RST_MIDDLE_CAP,
                       edge_text_cap:   RST_EDGE_CAP};
            clear_line_state();
            awaited_reports.delete();
            mismatches  = 0;
            reports_due = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_TEXT_KIND:    limits.text_kind_code  = cfg_data;
                    REG_LARGEST_KIND: limits.largest_kind    = cfg_data;
                    REG_LARGEST_ICON: limits.largest_icon    = cfg_data;
                    REG_MIDDLE_CAP:   limits.middle_text_cap = cfg_data;
                    REG_EDGE_CAP:     limits.edge_text_cap   = cfg_data;
                    default: ;
                endcase
            end
            if (byte_ch.valid && byte_ch.ready)
                parse_line_byte(byte_ch.data_byte, byte_ch.end_of_line);
            if (report_ch.valid && report_ch.ready)
            begin
                if (awaited_reports.size() == 0)
                begin
                    $error("result transfer with no result outstanding");
                    mismatches++;
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    check_field("is_verdict", want.is_verdict, report_ch.is_verdict);
                    check_field("slot_number", want.slot_number, report_ch.slot_number);
                    check_field("slot_kind", want.slot_kind, report_ch.slot_kind);
                    check_field("slot_icon", want.slot_icon, report_ch.slot_icon);
                    check_field("text_length", want.text_length, report_ch.text_length);
                    check_field("text_offset", want.text_offset, report_ch.text_offset);
                    check_field("line_ok", want.line_ok, report_ch.line_ok);
                    check_field("last", want.last, report_ch.last);
                end
            end
            reports_due = awaited_reports.size();
        end
    end

endmodule : status_line_checker

/* tb/status_slot_line_validator_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Status slot line validator testbench
// Feeds directed and randomized status lines (well-formed slots with random
// UTF-8 text, plus flipped, cut, padded, malformed and noise lines) under
// several register settings, with bursty input and a stalling result sink.
// The line checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module status_slot_line_validator_core_tb;
    import slvd_pkg::*;

    typedef enum int {RX_OPEN, RX_COIN, RX_CADENCE, RX_SPARSE} rx_mode_t;
    typedef enum int {
        LINE_GOOD, LINE_FLIP, LINE_CUT, LINE_TAIL, LINE_BAD_UTF8, LINE_BAD_LEN, LINE_NOISE
    } line_shape_t;
    typedef enum int {
        FLAW_LONE_CONT, FLAW_C0_C1, FLAW_HIGH_LEAD, FLAW_E0_LOW,
        FLAW_SURROGATE, FLAW_F0_LOW, FLAW_F4_HIGH, FLAW_NO_CONT
    } utf8_flaw_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int unsigned           mismatches;
    int unsigned           reports_due;

    cfg_t       cur_cfg;
    logic [7:0] line_q[$];
    int         burst_left;

    slvd_in_if  byte_ch();
    slvd_out_if report_ch();

    status_slot_line_validator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (byte_ch),
        .out_ch    (report_ch)
    );

    status_line_checker line_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .byte_ch     (byte_ch),
        .report_ch   (report_ch),
        .mismatches  (mismatches),
        .reports_due (reports_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // result sink: stall patterns, with a long hold-off now and then
    initial
    begin
        rx_mode_t mode;
        int       stretch;
        int       tick;
        int       hold_left;
        report_ch.ready <= 1'b0;
        tick = 0;
        hold_left = 0;
        forever
        begin
            mode = rx_mode_t'($urandom_range(0, 3));
            stretch = $urandom_range(30, 200);
            repeat (stretch)
            begin
                @(posedge clk);
                tick++;
                if (tick % 1500 == 700)
                    hold_left = 100;
                if (hold_left > 0)
                begin
                    hold_left--;
                    report_ch.ready <= 1'b0;
                end
                else
                begin
                    case (mode)
                        RX_OPEN:    report_ch.ready <= 1'b1;
                        RX_COIN:    report_ch.ready <= 1'($urandom_range(0, 1));
                        RX_CADENCE: report_ch.ready <= (tick % 3 != 0);
                        default:    report_ch.ready <= ($urandom_range(0, 3) == 0);
                    endcase
                end
            end
        end
    end

    function automatic int small_cap(input int cap, input int lim);
        return (cap < lim) ? cap : lim;
    endfunction

    function automatic int cont_byte();
        return $urandom_range(8'h80, 8'hBF);
    endfunction

    function automatic int slot_cap(input int slot);
        return (slot == 1) ? cur_cfg.middle_text_cap : cur_cfg.edge_text_cap;
    endfunction

    task automatic put(input int v);
        line_q.push_back(8'(v));
    endtask

    task automatic add_utf8_char(input int n);
        int lead;
        case (n)
            1: put($urandom_range(0, 8'h7F));
            2:
            begin
                put($urandom_range(8'hC2, 8'hDF));
                put(cont_byte());
            end
            3:
            begin
                lead = $urandom_range(8'hE0, 8'hEF);
                put(lead);
                if (lead == 8'hE0)
                    put($urandom_range(8'hA0, 8'hBF));
                else if (lead == 8'hED)
                    put($urandom_range(8'h80, 8'h9F));
                else
                    put(cont_byte());
                put(cont_byte());
            end
            default:
            begin
                lead = $urandom_range(8'hF0, 8'hF4);
                put(lead);
                if (lead == 8'hF0)
                    put($urandom_range(8'h90, 8'hBF));
                else if (lead == 8'hF4)
                    put($urandom_range(8'h80, 8'h8F));
                else
                    put(cont_byte());
                put(cont_byte());
                put(cont_byte());
            end
        endcase
    endtask

    task automatic add_text(input int n);
        int k;
        while (n > 0)
        begin
            k = $urandom_range(1, small_cap(n, 4));
            add_utf8_char(k);
            n -= k;
        end
    endtask

    task automatic add_bad_utf8();
        utf8_flaw_t flaw;
        flaw = utf8_flaw_t'($urandom_range(0, 7));
        case (flaw)
            FLAW_LONE_CONT: put(cont_byte());
            FLAW_C0_C1:
            begin
                put($urandom_range(8'hC0, 8'hC1));
                put(cont_byte());
            end
            FLAW_HIGH_LEAD: put($urandom_range(8'hF5, 8'hFF));
            FLAW_E0_LOW:
            begin
                put(8'hE0);
                put($urandom_range(8'h80, 8'h9F));
                put(cont_byte());
            end
            FLAW_SURROGATE:
            begin
                put(8'hED);
                put($urandom_range(8'hA0, 8'hBF));
                put(cont_byte());
            end
            FLAW_F0_LOW:
            begin
                put(8'hF0);
                put($urandom_range(8'h80, 8'h8F));
                put(cont_byte());
                put(cont_byte());
            end
            FLAW_F4_HIGH:
            begin
                put(8'hF4);
                put($urandom_range(8'h90, 8'hBF));
                put(cont_byte());
                put(cont_byte());
            end
            default:
            begin
                put($urandom_range(8'hC2, 8'hDF));
                if ($urandom_range(0, 1))
                    put($urandom_range(0, 8'h7F));
                else
                    put($urandom_range(8'hC0, 8'hFF));
            end
        endcase
    endtask

    task automatic add_good_slot(input int slot);
        int  cap;
        int  len;
        int  kind;
        logic text_ok;
        logic other_ok;
        cap = slot_cap(slot);
        text_ok = cur_cfg.text_kind_code <= cur_cfg.largest_kind;
        other_ok = !text_ok || cur_cfg.largest_kind != 8'd0;
        if (text_ok && (!other_ok || $urandom_range(0, 1)))
        begin
            if ($urandom_range(0, 9) < 7)
                len = $urandom_range(1, small_cap(cap, 6));
            else
                len = $urandom_range(1, cap);
            put(cur_cfg.text_kind_code);
            put($urandom_range(0, cur_cfg.largest_icon));
            put(len);
            add_text(len);
        end
        else
        begin
            do
                kind = $urandom_range(0, cur_cfg.largest_kind);
            while (kind == cur_cfg.text_kind_code);
            put(kind);
            put($urandom_range(0, cur_cfg.largest_icon));
            put(0);
        end
    endtask

    task automatic add_good_slots(input int count);
        for (int s = 0; s < count; s++)
            add_good_slot(s);
    endtask

    task automatic build_random_line();
        line_shape_t shape;
        int          roll;
        int          p;
        int          cap;
        int          len;
        int          keep;
        line_q.delete();
        roll = $urandom_range(0, 99);
        if (roll < 55)
            shape = LINE_GOOD;
        else if (roll < 63)
            shape = LINE_FLIP;
        else if (roll < 71)
            shape = LINE_CUT;
        else if (roll < 78)
            shape = LINE_TAIL;
        else if (roll < 88)
            shape = LINE_BAD_UTF8;
        else if (roll < 94)
            shape = LINE_BAD_LEN;
        else
            shape = LINE_NOISE;
        case (shape)
            LINE_GOOD: add_good_slots(SLOT_COUNT);
            LINE_FLIP:
            begin
                add_good_slots(SLOT_COUNT);
                line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom);
            end
            LINE_CUT:
            begin
                add_good_slots(SLOT_COUNT);
                keep = $urandom_range(1, line_q.size() - 1);
                while (line_q.size() > keep)
                    void'(line_q.pop_back());
            end
            LINE_TAIL:
            begin
                add_good_slots(SLOT_COUNT);
                repeat ($urandom_range(1, 3))
                    put($urandom);
            end
            LINE_BAD_UTF8:
            begin
                p = $urandom_range(0, SLOT_COUNT - 1);
                add_good_slots(p);
                cap = slot_cap(p);
                put(cur_cfg.text_kind_code);
                put($urandom_range(0, cur_cfg.largest_icon));
                if ($urandom_range(0, 3) == 0)
                begin
                    len = $urandom_range(1, cap);
                    put(len);
                    add_text(len - 1);
                    put($urandom_range(8'hC2, 8'hF4));
                end
                else
                begin
                    put((cap < 4) ? cap : $urandom_range(4, cap));
                    add_bad_utf8();
                end
                repeat ($urandom_range(0, 3))
                    put($urandom);
            end
            LINE_BAD_LEN:
            begin
                p = $urandom_range(0, SLOT_COUNT - 1);
                add_good_slots(p);
                roll = $urandom_range(0, 2);
                if (roll == 0)
                begin
                    put(cur_cfg.text_kind_code);
                    put($urandom_range(0, cur_cfg.largest_icon));
                    put(0);
                end
                else if (roll == 1)
                begin
                    put(cur_cfg.text_kind_code);
                    put($urandom_range(0, cur_cfg.largest_icon));
                    put(slot_cap(p) + 1);
                end
                else
                begin
                    put($urandom_range(0, cur_cfg.largest_kind));
                    put($urandom_range(0, cur_cfg.largest_icon));
                    put($urandom_range(1, 255));
                end
                repeat ($urandom_range(0, 4))
                    put($urandom);
            end
            default:
            begin
                repeat ($urandom_range(1, 12))
                    put($urandom);
            end
        endcase
    endtask

    // every slot a text slot at full cap, then padding out to the given size
    task automatic build_full_line(input int total);
        line_q.delete();
        for (int s = 0; s < SLOT_COUNT; s++)
        begin
            put(cur_cfg.text_kind_code);
            put($urandom_range(0, cur_cfg.largest_icon));
            put(slot_cap(s));
            add_text(slot_cap(s));
        end
        while (line_q.size() < total)
            put($urandom);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eol);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        byte_ch.valid       <= 1'b1;
        byte_ch.data_byte   <= b;
        byte_ch.end_of_line <= eol;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_line();
        for (int i = 0; i < line_q.size(); i++)
            send_byte(line_q[i], i == line_q.size() - 1);
    endtask

    task automatic run_random(input int budget);
        int sent;
        sent = 0;
        while (sent < budget)
        begin
            build_random_line();
            sent += line_q.size();
            send_line();
        end
    endtask

    task automatic settle();
        byte_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (reports_due != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic apply_settings(input cfg_t c);
        write_reg(REG_TEXT_KIND, c.text_kind_code);
        write_reg(REG_LARGEST_KIND, c.largest_kind);
        write_reg(REG_LARGEST_ICON, c.largest_icon);
        write_reg(REG_MIDDLE_CAP, c.middle_text_cap);
        write_reg(REG_EDGE_CAP, c.edge_text_cap);
        cfg_wr_en <= 1'b0;
        cur_cfg = c;
    endtask

    initial
    begin
        cfg_t c;
        byte_ch.valid       <= 1'b0;
        byte_ch.data_byte   <= 8'd0;
        byte_ch.end_of_line <= 1'b0;
        cfg_wr_en           <= 1'b0;
        cfg_index           <= REG_TEXT_KIND;
        cfg_data            <= 8'd0;
        rst_n               <= 1'b0;
        burst_left = 0;
        cur_cfg = '{text_kind_code:  RST_TEXT_KIND,
                    largest_kind:    RST_LARGEST_KIND,
                    largest_icon:    RST_LARGEST_ICON,
                    middle_text_cap: RST_MIDDLE_CAP,
                    edge_text_cap:   RST_EDGE_CAP};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // good line, top code point in the last slot
        line_q = '{8'h01, 8'h3F, 8'h01, 8'h41, 8'h03, 8'h00, 8'h00,
                   8'h01, 8'h05, 8'h04, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_line();
        // kind and icon both out of range
        line_q = '{8'h04, 8'h40, 8'h00};
        send_line();
        // surrogate
        line_q = '{8'h01, 8'h00, 8'h02, 8'hED, 8'hA0};
        send_line();
        // short line
        line_q = '{8'hFF};
        send_line();

        run_random(150);

        settle();
        apply_settings('{text_kind_code: 8'hFF, largest_kind: 8'hFF, largest_icon: 8'hFF,
                         middle_text_cap: 8'hFF, edge_text_cap: 8'hFF});
        build_full_line(MAX_LINE_BYTES + 6);
        send_line();
        run_random(100);

        settle();
        apply_settings('{text_kind_code: 8'd0, largest_kind: 8'd0, largest_icon: 8'd0,
                         middle_text_cap: 8'd1, edge_text_cap: 8'd1});
        run_random(70);

        settle();
        apply_settings('{text_kind_code: 8'd2, largest_kind: 8'd1, largest_icon: 8'd200,
                         middle_text_cap: 8'd3, edge_text_cap: 8'd255});
        run_random(60);

        repeat (2)
        begin
            settle();
            c.text_kind_code  = 8'($urandom_range(0, 5));
            c.largest_kind    = 8'($urandom_range(0, 5));
            c.largest_icon    = 8'($urandom_range(0, 255));
            c.middle_text_cap = 8'($urandom_range(1, 255));
            c.edge_text_cap   = 8'($urandom_range(1, 24));
            apply_settings(c);
            run_random(40);
        end

        settle();
        repeat (30) @(posedge clk);
        if (mismatches == 0 && reports_due == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule : status_slot_line_validator_core_tb

/* status_slot_line_validator_core.f */
rtl/slvd_pkg.sv
rtl/slvd_if.sv
rtl/slvd_parse.sv
rtl/slvd_rqueue.sv
rtl/status_slot_line_validator_core.sv
tb/status_line_checker.sv
tb/status_slot_line_validator_core_tb.sv
